[rtl/frame_repacker_timestamp_fix_core_macros.svh]
// Assertion macros used by the checker file.
`ifndef FRAME_REPACKER_TIMESTAMP_FIX_CORE_MACROS_SVH
`define FRAME_REPACKER_TIMESTAMP_FIX_CORE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define FRTF_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frame repacker check failed");

// Next-cycle implication, sampled on the rising clock edge.
`define FRTF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frame repacker check failed");

`endif

[rtl/frp_pkg.sv]
package frp_pkg;

    localparam int CFG_INDEX_W = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_DEVICE_ID     = 3'd0,
        CFG_HEAD_BYTE     = 3'd1,
        CFG_TAIL_WORD     = 3'd2,
        CFG_RESERVED_WORD = 3'd3,
        CFG_ENABLE        = 3'd4
    } cfg_idx_t;

    // Frame framing bytes
    localparam logic [7:0] FRAME_HEAD = 8'h5a;
    localparam logic [7:0] FRAME_CR   = 8'h0d;
    localparam logic [7:0] FRAME_LF   = 8'h0a;

    // Frame kind bytes
    localparam logic [7:0] SRC_NORMAL  = 8'ha5;
    localparam logic [7:0] SRC_RESTART = 8'h01;
    localparam logic [7:0] SRC_FAULT   = 8'h10;

    // Packet kind codes
    localparam logic [7:0] CODE_NORMAL  = 8'h01;
    localparam logic [7:0] CODE_RESTART = 8'h06;
    localparam logic [7:0] CODE_FAULT   = 8'h07;

    typedef enum logic [1:0] {
        KIND_NORMAL  = 2'd0,
        KIND_RESTART = 2'd1,
        KIND_FAULT   = 2'd2
    } kind_t;

    localparam logic [15:0] RESERVED_RESET = 16'hffff;

    typedef struct packed {
        logic [15:0] device_id;
        logic [7:0]  head_byte;
        logic [15:0] tail_word;
        logic [15:0] reserved_word;
        logic        enable;
    } cfg_t;

    typedef struct packed {
        logic [63:0] hi;
        logic [63:0] lo;
        kind_t       kind;
        logic        fixed;
        logic        last;
    } pkt_t;

    // One queue entry: one or two packets caused by a single frame
    typedef struct packed {
        pkt_t first;
        pkt_t second;
        logic two;
    } job_t;

endpackage

[rtl/frp_front.sv]
module frp_front (
    input  logic               clk,
    input  logic               rst_n,
    input  frp_pkg::cfg_t      cfg,
    input  logic               accept,
    input  logic [63:0]        frame_bytes,
    input  logic [31:0]        stamp_secs,
    output logic               job_valid,
    output frp_pkg::job_t      job
);

    logic        holding_reg, holding_next;
    logic [31:0] prev_time_reg, prev_time_next;
    logic [31:0] repeat_time_reg, repeat_time_next;
    logic [31:0] loss_time_reg, loss_time_next;
    logic [63:0] held_hi_reg, held_hi_next;
    logic [63:0] held_lo_reg, held_lo_next;

    logic [7:0]     b0, b1, b6, b7;
    logic           kind_ok;
    logic [7:0]     code;
    frp_pkg::kind_t kind;
    logic [63:0]    hi, lo, hlo;
    logic [31:0]    diff_prev, diff_loss, diff_rep;
    logic           is_repeat, is_loss, fix;
    logic           frame_ok;

    assign b0 = frame_bytes[63:56];
    assign b1 = frame_bytes[55:48];
    assign b6 = frame_bytes[15:8];
    assign b7 = frame_bytes[7:0];

    always_comb
    begin
        kind_ok = 1'b1;
        code    = frp_pkg::CODE_NORMAL;
        kind    = frp_pkg::KIND_NORMAL;
        unique case (b1)
            frp_pkg::SRC_NORMAL:
            begin
                code = frp_pkg::CODE_NORMAL;
                kind = frp_pkg::KIND_NORMAL;
            end
            frp_pkg::SRC_RESTART:
            begin
                code = frp_pkg::CODE_RESTART;
                kind = frp_pkg::KIND_RESTART;
            end
            frp_pkg::SRC_FAULT:
            begin
                code = frp_pkg::CODE_FAULT;
                kind = frp_pkg::KIND_FAULT;
            end
            default:
                kind_ok = 1'b0;
        endcase
    end

    assign frame_ok = accept && cfg.enable && kind_ok && (b0 == frp_pkg::FRAME_HEAD)
                      && (b6 == frp_pkg::FRAME_CR) && (b7 == frp_pkg::FRAME_LF);

    assign hi = {cfg.head_byte, code, cfg.device_id, frame_bytes[47:16]};
    assign lo = {stamp_secs, cfg.reserved_word, cfg.tail_word};

    assign diff_prev = stamp_secs - prev_time_reg;
    assign diff_loss = stamp_secs - loss_time_reg;
    assign diff_rep  = stamp_secs - repeat_time_reg;

    // Signed difference above one: positive and at least two
    assign is_repeat = (stamp_secs == prev_time_reg);
    assign is_loss   = !is_repeat && (prev_time_reg != 32'd0) && !diff_prev[31]
                       && (diff_prev[30:1] != 30'd0);

    always_comb
    begin
        holding_next     = holding_reg;
        prev_time_next   = prev_time_reg;
        repeat_time_next = repeat_time_reg;
        loss_time_next   = loss_time_reg;
        held_hi_next     = held_hi_reg;
        held_lo_next     = held_lo_reg;
        hlo              = held_lo_reg;
        fix              = 1'b0;
        job_valid        = 1'b0;

        if (is_repeat && (diff_loss == 32'd1))
        begin
            fix = 1'b1;
            hlo = {loss_time_reg, held_lo_reg[31:0]};
        end
        else if (is_loss && (diff_rep == 32'd2))
        begin
            fix = 1'b1;
            hlo = {repeat_time_reg + 32'd1, held_lo_reg[31:0]};
        end

        job.first  = '{hi: hi, lo: lo, kind: kind, fixed: 1'b0, last: 1'b1};
        job.second = '{hi: hi, lo: lo, kind: kind, fixed: 1'b0, last: 1'b1};
        job.two    = 1'b0;

        if (frame_ok)
        begin
            if (kind != frp_pkg::KIND_NORMAL)
            begin
                job_valid = 1'b1;
            end
            else
            begin
                prev_time_next = stamp_secs;
                if (is_repeat)
                begin
                    repeat_time_next = stamp_secs;
                end
                else if (is_loss)
                begin
                    loss_time_next = stamp_secs - 32'd1;
                end

                if (!holding_reg)
                begin
                    held_hi_next = hi;
                    held_lo_next = lo;
                    // Hold back on a repeat or a gap, emit otherwise
                    if (is_repeat || is_loss)
                    begin
                        holding_next = 1'b1;
                    end
                    else
                    begin
                        job_valid = 1'b1;
                    end
                end
                else
                begin
                    // Release the held packet ahead of the new one
                    holding_next = 1'b0;
                    job_valid    = 1'b1;
                    job.two      = 1'b1;
                    job.first    = '{hi: held_hi_reg, lo: hlo, kind: frp_pkg::KIND_NORMAL,
                                     fixed: fix, last: 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            holding_reg     <= 1'b0;
            prev_time_reg   <= 32'd0;
            repeat_time_reg <= 32'd0;
            loss_time_reg   <= 32'd0;
        end
        else
        begin
            holding_reg     <= holding_next;
            prev_time_reg   <= prev_time_next;
            repeat_time_reg <= repeat_time_next;
            loss_time_reg   <= loss_time_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_hi_reg <= held_hi_next;
        held_lo_reg <= held_lo_next;
    end

endmodule

[rtl/frp_queue.sv]
module frp_queue #(
    parameter int DEPTH = 2
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  frp_pkg::job_t wr_job,
    input  logic          rd_en,
    output frp_pkg::job_t rd_job,
    output logic          full,
    output logic          not_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    frp_pkg::job_t    entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full      = (count_reg == CNT_FULL);
    assign not_empty = (count_reg != '0);
    assign do_wr     = wr_en && !full;
    assign do_rd     = rd_en && not_empty;
    assign rd_job    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_job;
        end
    end

endmodule

[rtl/frp_back.sv]
module frp_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          job_valid,
    input  frp_pkg::job_t job,
    output logic          job_pop,
    input  logic          out_take,
    output logic          out_valid,
    output frp_pkg::pkt_t out_pkt
);

    logic          out_valid_reg, out_valid_next;
    frp_pkg::pkt_t out_pkt_reg, out_pkt_next;
    logic          second_reg, second_next;
    logic          load;

    assign load      = !out_valid_reg || out_take;
    assign out_valid = out_valid_reg;
    assign out_pkt   = out_pkt_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_pkt_next   = out_pkt_reg;
        second_next    = second_reg;
        job_pop        = 1'b0;
        if (load)
        begin
            out_valid_next = job_valid;
            if (job_valid)
            begin
                out_pkt_next = second_reg ? job.second : job.first;
                // Advance to the second packet, or retire the entry
                if (!second_reg && job.two)
                begin
                    second_next = 1'b1;
                end
                else
                begin
                    second_next = 1'b0;
                    job_pop     = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            second_reg    <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            second_reg    <= second_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_pkt_reg <= out_pkt_next;
    end

endmodule

[rtl/frame_repacker_timestamp_fix_core.sv]
// Sensor frame repacker with timestamp repair.
// Input queue side: drive frame_bytes and stamp_secs with push; a frame is
// taken on a clock edge where push is high and full is low. Bad or unknown
// frames, and all frames while enable is 0, are taken and dropped.
// Result queue side: while empty is low the oldest packet sits on
// packet_high, packet_low, packet_kind, time_fixed and last_of_run; pop
// takes it. A frame makes zero, one or two packets (two when it releases a
// held packet; last_of_run marks the final one).
// With the queue and output stage empty, the first packet of a frame is
// written into the job queue, then registered in the output stage.
// Throughput: one frame per cycle at the input while the job queue has room;
// the output stage moves one packet per cycle while pop is high. QUEUE_DEPTH
// entries decouple classification from output.
// Configuration: cfg_valid/cfg_ready writes register cfg_index; cfg_ready is
// always high. Write only while idle.
// Reset clears the time tracking, the held flag, the queue and the output
// stage; registers return to zero, reserved_word to 0xFFFF.
// When pop stays low the packet holds, the queue fills and full rises.
module frame_repacker_timestamp_fix_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic [63:0]                      frame_bytes,
    input  logic [31:0]                      stamp_secs,
    output logic                             empty,
    input  logic                             pop,
    output logic [63:0]                      packet_high,
    output logic [63:0]                      packet_low,
    output logic [1:0]                       packet_kind,
    output logic                             time_fixed,
    output logic                             last_of_run,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [frp_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [15:0]                      cfg_data
);

    frp_pkg::cfg_t cfg_reg, cfg_next;
    frp_pkg::job_t front_job, queue_job;
    frp_pkg::pkt_t out_pkt;
    logic          front_valid, queue_not_empty, queue_pop, out_valid;
    logic          accept;

    assign cfg_ready = 1'b1;
    assign accept    = push && !full;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                frp_pkg::CFG_DEVICE_ID:     cfg_next.device_id     = cfg_data;
                frp_pkg::CFG_HEAD_BYTE:     cfg_next.head_byte     = cfg_data[7:0];
                frp_pkg::CFG_TAIL_WORD:     cfg_next.tail_word     = cfg_data;
                frp_pkg::CFG_RESERVED_WORD: cfg_next.reserved_word = cfg_data;
                frp_pkg::CFG_ENABLE:        cfg_next.enable        = cfg_data[0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{device_id: 16'd0, head_byte: 8'd0, tail_word: 16'd0,
                         reserved_word: frp_pkg::RESERVED_RESET, enable: 1'b0};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    frp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .accept      (accept),
        .frame_bytes (frame_bytes),
        .stamp_secs  (stamp_secs),
        .job_valid   (front_valid),
        .job         (front_job)
    );

    frp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (front_valid),
        .wr_job    (front_job),
        .rd_en     (queue_pop),
        .rd_job    (queue_job),
        .full      (full),
        .not_empty (queue_not_empty)
    );

    frp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (queue_not_empty),
        .job       (queue_job),
        .job_pop   (queue_pop),
        .out_take  (pop),
        .out_valid (out_valid),
        .out_pkt   (out_pkt)
    );

    assign empty       = !out_valid;
    assign packet_high = out_pkt.hi;
    assign packet_low  = out_pkt.lo;
    assign packet_kind = out_pkt.kind;
    assign time_fixed  = out_pkt.fixed;
    assign last_of_run = out_pkt.last;

endmodule

[rtl/frp_checker.sv]
`include "frame_repacker_timestamp_fix_core_macros.svh"

module frp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        empty,
    input logic        pop,
    input logic [63:0] packet_high,
    input logic [1:0]  packet_kind,
    input logic        time_fixed,
    input logic        last_of_run
);

    // A released held packet is always followed at once by its partner
    `FRTF_ASSERT_NXT(a_pair_follows, clk, rst_n, !empty && pop && !last_of_run,
        !empty && last_of_run)
    // Only a released held packet carries a corrected time
    `FRTF_ASSERT_NOW(a_fix_not_last, clk, rst_n, !empty && time_fixed, !last_of_run)
    // Restart and fault packets stand alone and are never corrected
    `FRTF_ASSERT_NOW(a_event_single, clk, rst_n,
        !empty && packet_kind != frp_pkg::KIND_NORMAL, last_of_run && !time_fixed)
    `FRTF_ASSERT_NOW(a_kind_code, clk, rst_n, !empty, packet_kind != 2'd3)
    `FRTF_ASSERT_NXT(a_hold_stalled, clk, rst_n, !empty && !pop,
        !empty && $stable(packet_high))

endmodule

bind frame_repacker_timestamp_fix_core frp_checker u_frp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .empty       (empty),
    .pop         (pop),
    .packet_high (packet_high),
    .packet_kind (packet_kind),
    .time_fixed  (time_fixed),
    .last_of_run (last_of_run)
);
